### rtl/ndd_pkg.sv
`timescale 1ns / 1ps

package ndd_pkg;

    localparam int VALUE_W             = 32;
    localparam int DIGIT_W             = 4;
    localparam int SHOWN_DIGITS        = 5;
    localparam int MAX_DIGITS          = 10;
    localparam int DIGIT_COUNT_DEFAULT = 5;

    // double dabble is split into equal slices of input bits
    localparam int DABBLE_STEPS  = 8;
    localparam int DABBLE_STAGES = VALUE_W / DABBLE_STEPS;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_in;
        logic                      row_select;
        logic                      hex_mode;
        logic                      fill_zeros;
    } in_item_t;

    typedef struct packed {
        logic               row_out;
        logic               minus_shown;
        logic [DIGIT_W-1:0] digit_four;
        logic [DIGIT_W-1:0] digit_three;
        logic [DIGIT_W-1:0] digit_two;
        logic [DIGIT_W-1:0] digit_one;
        logic [DIGIT_W-1:0] digit_zero;
        logic [SHOWN_DIGITS-1:0] visible_mask;
    } out_item_t;

    typedef struct packed {
        logic row;
        logic minus;
        logic hex;
        logic fill;
    } ctl_t;

endpackage

### rtl/ndd_dabble.sv
`timescale 1ns / 1ps

module ndd_dabble #(
    parameter int DIGIT_COUNT = ndd_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic [ndd_pkg::DABBLE_STEPS-1:0]         bits_in,
    input  logic [ndd_pkg::DIGIT_W*DIGIT_COUNT-1:0]  bcd_in,
    output logic [ndd_pkg::DIGIT_W*DIGIT_COUNT-1:0]  bcd_out
);

    localparam int BCD_W = ndd_pkg::DIGIT_W * DIGIT_COUNT;

    logic [BCD_W-1:0] bcd;

    // add 3 to every digit of 5 or more, then shift in the next bit, msb first
    always_comb begin
        bcd = bcd_in;
        for (int s = 0; s < ndd_pkg::DABBLE_STEPS; s++) begin
            for (int j = 0; j < DIGIT_COUNT; j++) begin
                if (bcd[j*ndd_pkg::DIGIT_W +: ndd_pkg::DIGIT_W] >= 4'd5) begin
                    bcd[j*ndd_pkg::DIGIT_W +: ndd_pkg::DIGIT_W] =
                        bcd[j*ndd_pkg::DIGIT_W +: ndd_pkg::DIGIT_W] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bits_in[ndd_pkg::DABBLE_STEPS-1-s]};
        end
        bcd_out = bcd;
    end

endmodule

### rtl/number_to_display_digits_unit.sv
`timescale 1ns / 1ps

// channel  | ports                        | item
// ---------+------------------------------+---------------------------------------
// input    | s_valid, s_ready, s_item     | value_in, row_select, hex_mode, fill
// result   | m_valid, m_ready, m_item     | row, minus flag, five digits, mask
//
// one item per cycle while the result side is not stalled; six register stages from accept to result
// stages: magnitude, four double dabble slices of eight bits each, digit select and blanking
// aresetn (synchronous, active low) empties the pipeline; payload registers keep their data
// a stall holds every full stage; bubbles still close up, so input is refused only when full

module number_to_display_digits_unit #(
    parameter int DIGIT_COUNT = ndd_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ndd_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ndd_pkg::out_item_t m_item
);

    localparam int BCD_W  = ndd_pkg::DIGIT_W * DIGIT_COUNT;
    localparam int NSL    = ndd_pkg::DABBLE_STAGES;
    localparam int LAST   = NSL + 1;
    localparam int DVEC_W = ndd_pkg::DIGIT_W * ndd_pkg::MAX_DIGITS;
    localparam int DW     = ndd_pkg::DIGIT_W;

    logic [LAST:0]                 valid_reg;
    logic [LAST:0]                 stage_ready;
    ndd_pkg::ctl_t                 ctl_reg [0:NSL];
    logic [ndd_pkg::VALUE_W-1:0]   mag_reg [0:NSL];
    logic [BCD_W-1:0]              bcd_reg [1:NSL];
    logic [BCD_W-1:0]              bcd_src [1:NSL];
    logic [BCD_W-1:0]              bcd_calc [1:NSL];
    ndd_pkg::out_item_t            out_reg;
    ndd_pkg::out_item_t            out_next;
    ndd_pkg::ctl_t                 ctl_next;
    logic [ndd_pkg::VALUE_W-1:0]   mag_next;
    logic [DVEC_W-1:0]             dvec;
    logic [ndd_pkg::SHOWN_DIGITS-1:0] mask;
    logic                          lit;

    // ready chain, a stage takes data when empty or when it moves on
    assign stage_ready[LAST] = !valid_reg[LAST] || m_ready;
    genvar r;
    generate
        for (r = 0; r < LAST; r++) begin : g_ready
            assign stage_ready[r] = !valid_reg[r] || stage_ready[r+1];
        end
    endgenerate

    assign s_ready = stage_ready[0];
    assign m_valid = valid_reg[LAST];
    assign m_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i <= LAST; i++) begin
                if (stage_ready[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // sign and magnitude
    always_comb begin
        ctl_next.row   = s_item.row_select;
        ctl_next.minus = s_item.value_in[ndd_pkg::VALUE_W-1];
        ctl_next.hex   = s_item.hex_mode;
        ctl_next.fill  = s_item.fill_zeros;
        mag_next = s_item.value_in[ndd_pkg::VALUE_W-1] ?
                   (ndd_pkg::VALUE_W'(0) - ndd_pkg::VALUE_W'(s_item.value_in)) :
                   ndd_pkg::VALUE_W'(s_item.value_in);
    end

    // double dabble slices
    genvar g;
    generate
        for (g = 1; g <= NSL; g++) begin : g_slice
            if (g == 1) begin : g_first
                assign bcd_src[g] = '0;
            end else begin : g_rest
                assign bcd_src[g] = bcd_reg[g-1];
            end
            ndd_dabble #(
                .DIGIT_COUNT(DIGIT_COUNT)
            ) u_dabble (
                .bits_in(mag_reg[g-1][ndd_pkg::VALUE_W-1-ndd_pkg::DABBLE_STEPS*(g-1) -:
                                      ndd_pkg::DABBLE_STEPS]),
                .bcd_in (bcd_src[g]),
                .bcd_out(bcd_calc[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (stage_ready[0] && s_valid) begin
            mag_reg[0] <= mag_next;
            ctl_reg[0] <= ctl_next;
        end
        for (int i = 1; i <= NSL; i++) begin
            if (stage_ready[i] && valid_reg[i-1]) begin
                mag_reg[i] <= mag_reg[i-1];
                ctl_reg[i] <= ctl_reg[i-1];
                bcd_reg[i] <= bcd_calc[i];
            end
        end
    end

    // digit select, truncation and leading zero blanking
    always_comb begin
        dvec = '0;
        if (ctl_reg[NSL].hex) begin
            dvec[ndd_pkg::VALUE_W-1:0] = mag_reg[NSL];
        end else begin
            dvec[BCD_W-1:0] = bcd_reg[NSL];
        end
        lit  = ctl_reg[NSL].fill;
        mask = '0;
        for (int k = ndd_pkg::MAX_DIGITS - 1; k >= 0; k--) begin
            if (k >= DIGIT_COUNT) begin
                dvec[k*DW +: DW] = '0;
            end
            if (dvec[k*DW +: DW] != '0) begin
                lit = 1'b1;
            end
            if (k < ndd_pkg::SHOWN_DIGITS && k < DIGIT_COUNT) begin
                mask[k] = lit;
            end
        end
        out_next.row_out      = ctl_reg[NSL].row;
        out_next.minus_shown  = ctl_reg[NSL].minus;
        out_next.digit_four   = dvec[4*DW +: DW];
        out_next.digit_three  = dvec[3*DW +: DW];
        out_next.digit_two    = dvec[2*DW +: DW];
        out_next.digit_one    = dvec[1*DW +: DW];
        out_next.digit_zero   = dvec[0*DW +: DW];
        out_next.visible_mask = mask;
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[LAST] && valid_reg[LAST-1]) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_mask_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.visible_mask & (m_item.visible_mask + 5'd1)) == 5'd0))
        else $error("visible mask not contiguous from the low digit");

    a_blank_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.visible_mask[0]) |->
        (m_item.digit_zero == '0 && m_item.digit_one == '0 && m_item.digit_two == '0 &&
         m_item.digit_three == '0 && m_item.digit_four == '0))
        else $error("blank result carries a nonzero digit");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&valid_reg) && !m_ready) |-> !s_ready)
        else $error("item taken while pipeline full and stalled");

    a_accept_fills_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted item not held in front stage");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ndd_pkg::*;

    localparam int DIGIT_COUNT  = DIGIT_COUNT_DEFAULT;
    localparam int RESET_CYCLES = 6;
    localparam int DIR_ROWS     = 24;
    localparam int PHASE_ITEMS  = 220;
    localparam int PRESS_ITEMS  = 70;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT        = 200000;
    localparam int PRINT_CAP    = 40;

    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;
    localparam logic BLANK    = 1'b0;
    localparam logic FILL     = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      row;
        logic                      mode;
        logic                      fill;
        logic                      known;
        out_item_t                 want;
    } dir_row_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    out_item_t expected_digits[$];
    in_item_t  pending_numbers[$];

    int  src_idle_pct  = 0;
    int  sink_stall_pct = 0;
    int  mismatches    = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  input_stalls  = 0;
    int  cycles        = 0;
    bit  hold_go       = 1'b0;
    logic hold_off     = 1'b0;

    int src_plan  [4] = '{0, 51, 0, 18};
    int sink_plan [4] = '{0, 0, 51, 18};

    // extremes, overflow past five digits, blanking and the minus flag
    dir_row_t directed_rows [0:DIR_ROWS-1] = '{
        '{32'sh0000_0000, 1'b0, MODE_DEC, BLANK, 1'b1,
          '{1'b0, 1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 5'b00000}},
        '{32'sh0000_0000, 1'b1, MODE_HEX, FILL, 1'b1,
          '{1'b1, 1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 5'b11111}},
        '{-32'sd1, 1'b1, MODE_DEC, BLANK, 1'b1,
          '{1'b1, 1'b1, 4'h0, 4'h0, 4'h0, 4'h0, 4'h1, 5'b00001}},
        '{-32'sd1, 1'b0, MODE_HEX, FILL, 1'b1,
          '{1'b0, 1'b1, 4'h0, 4'h0, 4'h0, 4'h0, 4'h1, 5'b11111}},
        '{32'sh7fff_ffff, 1'b0, MODE_HEX, BLANK, 1'b1,
          '{1'b0, 1'b0, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 5'b11111}},
        '{32'sh7fff_ffff, 1'b1, MODE_DEC, BLANK, 1'b1,
          '{1'b1, 1'b0, 4'h8, 4'h3, 4'h6, 4'h4, 4'h7, 5'b11111}},
        '{32'sh8000_0000, 1'b0, MODE_HEX, BLANK, 1'b1,
          '{1'b0, 1'b1, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 5'b00000}},
        '{32'sh8000_0000, 1'b1, MODE_HEX, FILL, 1'b1,
          '{1'b1, 1'b1, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 5'b11111}},
        '{32'sh8000_0000, 1'b0, MODE_DEC, BLANK, 1'b1,
          '{1'b0, 1'b1, 4'h8, 4'h3, 4'h6, 4'h4, 4'h8, 5'b11111}},
        '{32'sd100000, 1'b0, MODE_DEC, BLANK, 1'b1,
          '{1'b0, 1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 5'b00000}},
        '{32'sd99999, 1'b1, MODE_DEC, BLANK, 1'b1,
          '{1'b1, 1'b0, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 5'b11111}},
        '{-32'sd99999, 1'b0, MODE_DEC, BLANK, 1'b1,
          '{1'b0, 1'b1, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 5'b11111}},
        '{32'sh000f_ffff, 1'b0, MODE_HEX, BLANK, 1'b1,
          '{1'b0, 1'b0, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 5'b11111}},
        '{32'sh0010_0000, 1'b1, MODE_HEX, BLANK, 1'b1,
          '{1'b1, 1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 5'b00000}},
        '{32'sd42, 1'b0, MODE_DEC, BLANK, 1'b1,
          '{1'b0, 1'b0, 4'h0, 4'h0, 4'h0, 4'h4, 4'h2, 5'b00011}},
        '{32'sd42, 1'b0, MODE_DEC, FILL, 1'b1,
          '{1'b0, 1'b0, 4'h0, 4'h0, 4'h0, 4'h4, 4'h2, 5'b11111}},
        '{32'sh0000_0100, 1'b1, MODE_HEX, BLANK, 1'b1,
          '{1'b1, 1'b0, 4'h0, 4'h0, 4'h1, 4'h0, 4'h0, 5'b00111}},
        '{32'sd10000, 1'b0, MODE_DEC, BLANK, 1'b1,
          '{1'b0, 1'b0, 4'h1, 4'h0, 4'h0, 4'h0, 4'h0, 5'b11111}},
        '{32'sd1000005, 1'b0, MODE_DEC, BLANK, 1'b1,
          '{1'b0, 1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h5, 5'b00001}},
        '{-32'sd12345, 1'b1, MODE_DEC, BLANK, 1'b0, '0},
        '{32'sh0001_abcd, 1'b0, MODE_HEX, BLANK, 1'b0, '0},
        '{-32'sh0000_beef, 1'b1, MODE_HEX, FILL, 1'b0, '0},
        '{32'sd7, 1'b1, MODE_HEX, FILL, 1'b0, '0},
        '{32'sd305419896, 1'b0, MODE_DEC, FILL, 1'b0, '0}
    };

    number_to_display_digits_unit #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic out_item_t display_digits_of(input in_item_t it);
        out_item_t         r;
        logic [VALUE_W-1:0] raw;
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] q;
        logic [VALUE_W-1:0] radix;
        logic [DIGIT_W-1:0] d;
        logic               lit;
        int                 k;
        int                 s;
        r     = '0;
        raw   = it.value_in;
        mag   = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
        radix = (it.hex_mode == MODE_HEX) ? 32'd16 : 32'd10;
        lit   = (it.fill_zeros == FILL);
        r.row_out     = it.row_select;
        r.minus_shown = raw[VALUE_W-1];
        for (k = DIGIT_COUNT - 1; k >= 0; k--) begin
            q = mag;
            for (s = 0; s < k; s++)
                q = q / radix;
            d = DIGIT_W'(q % radix);
            if (d != 0)
                lit = 1'b1;
            if (k < SHOWN_DIGITS) begin
                case (k)
                    4: r.digit_four  = d;
                    3: r.digit_three = d;
                    2: r.digit_two   = d;
                    1: r.digit_one   = d;
                    default: r.digit_zero = d;
                endcase
                if (lit)
                    r.visible_mask[k] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic in_item_t random_number_item();
        in_item_t           it;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        int                 sel;
        it = '0;
        it.row_select = 1'($urandom_range(1));
        it.hex_mode   = 1'($urandom_range(1));
        it.fill_zeros = 1'($urandom_range(1));
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2: v = $urandom;
            3, 4:    v = $urandom_range(99999);
            5:       v = $urandom_range(32'h000f_ffff);
            6:       v = $urandom_range(999);
            7: begin
                // near a power of the radix, including wrapped ones
                p = 32'd1;
                repeat ($urandom_range(9))
                    p = p * ((it.hex_mode == MODE_HEX) ? 32'd16 : 32'd10);
                v = p + $urandom_range(2) - 1;
            end
            default: begin
                case ($urandom_range(3))
                    0: v = 32'h0000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = 32'h8000_0000;
                    default: v = 32'hffff_ffff;
                endcase
            end
        endcase
        if (sel >= 3 && sel <= 7 && $urandom_range(1) == 1)
            v = 32'd0 - v;
        it.value_in = v;
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic compare_digits(input out_item_t got, input out_item_t want,
                                  input in_item_t src);
        string diff;
        diff = "";
        if (got.row_out !== want.row_out)         diff = {diff, " row_out"};
        if (got.minus_shown !== want.minus_shown) diff = {diff, " minus_shown"};
        if (got.digit_four !== want.digit_four)   diff = {diff, " digit_four"};
        if (got.digit_three !== want.digit_three) diff = {diff, " digit_three"};
        if (got.digit_two !== want.digit_two)     diff = {diff, " digit_two"};
        if (got.digit_one !== want.digit_one)     diff = {diff, " digit_one"};
        if (got.digit_zero !== want.digit_zero)   diff = {diff, " digit_zero"};
        if (got.visible_mask !== want.visible_mask)
            diff = {diff, " visible_mask"};
        if (diff != "")
            report_mismatch($sformatf("value %h hex %b fill %b:%s got %h want %h",
                src.value_in, src.hex_mode, src.fill_zeros, diff, got, want));
    endtask

    task automatic offer(input in_item_t it, input out_item_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        expected_digits.push_back(want);
        pending_numbers.push_back(it);
        items_sent++;
    endtask

    always @(posedge aclk) begin
        m_ready <= hold_off ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);
    end

    // long receiver hold-off so the pipeline fills and input backs up
    initial begin
        wait (hold_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready)
            input_stalls++;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_digits.size() == 0)
                report_mismatch($sformatf("unexpected item %h", m_item));
            else
                compare_digits(m_item, expected_digits.pop_front(),
                               pending_numbers.pop_front());
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("run limit of %0d cycles reached, %0d results outstanding",
                     LIMIT, expected_digits.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        in_item_t it;
        int       i;
        int       p;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < DIR_ROWS; i++) begin
            it.value_in   = directed_rows[i].value;
            it.row_select = directed_rows[i].row;
            it.hex_mode   = directed_rows[i].mode;
            it.fill_zeros = directed_rows[i].fill;
            offer(it, directed_rows[i].known ? directed_rows[i].want
                                             : display_digits_of(it));
        end

        for (p = 0; p < 4; p++) begin
            src_idle_pct   = src_plan[p];
            sink_stall_pct = sink_plan[p];
            repeat (PHASE_ITEMS) begin
                it = random_number_item();
                offer(it, display_digits_of(it));
            end
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_go        = 1'b1;
        repeat (PRESS_ITEMS) begin
            it = random_number_item();
            offer(it, display_digits_of(it));
        end
        s_valid <= 1'b0;

        while (expected_digits.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d numbers converted, %0d results checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("decimal and hex, blanked and filled, idle/stall mixes, %0d cycles %s",
                 input_stalls, "of input back-pressure");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
